// File: rtl/core/gab_pkg.sv
// ----------------------------------------------------------------------------
// gab_pkg
// Shared types and constants for the glyph alpha blit block.
// ----------------------------------------------------------------------------
package gab_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned GLYPH_W    = 8;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned PIX_W      = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd6;

  // Reset values
  localparam logic [DIM_W-1:0] FB_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] FB_HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_BLEND
  } gab_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;   // register input beat, advance position counters
    logic calc;      // effective alpha and address product
    logic load_out;  // blend and load output register
  } gab_cmd_t;

endpackage

// File: rtl/core/gab_ctrl.sv
// ----------------------------------------------------------------------------
// gab_ctrl
// Sequencer: capture, multiply, blend; owns the handshake and output valid.
// ----------------------------------------------------------------------------
module gab_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gab_pkg::gab_cmd_t cmd
);

  gab_pkg::gab_state_t state, state_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gab_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      gab_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = gab_pkg::ST_ALPHA;
        end
      end
      gab_pkg::ST_ALPHA: begin
        cmd.calc   = 1'b1;
        state_next = gab_pkg::ST_BLEND;
      end
      gab_pkg::ST_BLEND: begin
        // output register free or draining this cycle
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = gab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gab_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output loaded over a stalled beat");

  a_capture_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == gab_pkg::ST_ALPHA))
    else $error("capture not followed by alpha step");

  a_alpha_seq: assert property (@(posedge clk) disable iff (rst)
    (state == gab_pkg::ST_ALPHA) |=> (state == gab_pkg::ST_BLEND))
    else $error("alpha step not followed by blend");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid without a load");
`endif

endmodule

// File: rtl/core/gab_dp.sv
// ----------------------------------------------------------------------------
// gab_dp
// Datapath: config registers, position counters, clip, alpha and blend.
// ----------------------------------------------------------------------------
module gab_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [gab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gab_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  gab_pkg::gab_cmd_t                   cmd,
  input  logic [7:0]                          coverage,
  input  logic [31:0]                         dst_pixel,
  output logic                                write_enable,
  output logic [gab_pkg::ADDR_W-1:0]          pixel_address,
  output logic [gab_pkg::PIX_W-1:0]           new_pixel,
  output logic                                last
);

  // config
  logic [31:0]                      blend_color;
  logic [gab_pkg::DIM_W-1:0]        fb_width;
  logic [gab_pkg::DIM_W-1:0]        fb_height;
  logic [gab_pkg::DIM_W-1:0]        origin_x;
  logic [gab_pkg::DIM_W-1:0]        origin_y;
  logic [gab_pkg::GLYPH_W-1:0]      glyph_width;
  logic [gab_pkg::GLYPH_W-1:0]      glyph_height;

  // position
  logic [gab_pkg::GLYPH_W-1:0]      column_count;
  logic [gab_pkg::GLYPH_W-1:0]      row_count;
  logic [gab_pkg::GLYPH_W-1:0]      gw, gh;
  logic                             end_col, end_row;
  logic [gab_pkg::DIM_W:0]          ix, iy;
  logic                             visible;

  // stage registers
  logic [7:0]                       cov_q;
  logic [31:0]                      dst_q;
  logic [gab_pkg::DIM_W-1:0]        ix_q, iy_q;
  logic                             vis_q, last_q;
  logic [7:0]                       a_q;
  logic [gab_pkg::ADDR_W-1:0]       addr_q;

  logic [15:0]                      alpha_prod;
  logic [2*gab_pkg::DIM_W-1:0]      row_base;
  logic [7:0]                       r_bl, g_bl, b_bl;

  function automatic logic [7:0] blend_ch(input logic [7:0] c, input logic [7:0] d,
                                          input logic [7:0] a);
    logic [15:0] sum;
    sum = (16'(c) * 16'(a)) + (16'(d) * 16'(8'hff - a));
    return sum[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_color  <= '0;
      fb_width     <= gab_pkg::FB_WIDTH_RST;
      fb_height    <= gab_pkg::FB_HEIGHT_RST;
      origin_x     <= '0;
      origin_y     <= '0;
      glyph_width  <= '0;
      glyph_height <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gab_pkg::REG_BLEND_COLOR:  blend_color  <= cfg_data;
        gab_pkg::REG_FB_WIDTH:     fb_width     <= cfg_data[gab_pkg::DIM_W-1:0];
        gab_pkg::REG_FB_HEIGHT:    fb_height    <= cfg_data[gab_pkg::DIM_W-1:0];
        gab_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data[gab_pkg::DIM_W-1:0];
        gab_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data[gab_pkg::DIM_W-1:0];
        gab_pkg::REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[gab_pkg::GLYPH_W-1:0];
        gab_pkg::REG_GLYPH_HEIGHT: glyph_height <= cfg_data[gab_pkg::GLYPH_W-1:0];
        default: ;
      endcase
    end
  end

  // zero dimension acts as one
  assign gw      = (glyph_width  == '0) ? 8'd1 : glyph_width;
  assign gh      = (glyph_height == '0) ? 8'd1 : glyph_height;
  assign end_col = ({1'b0, column_count} + 9'd1) >= {1'b0, gw};
  assign end_row = ({1'b0, row_count} + 9'd1) >= {1'b0, gh};

  // signed origin plus unsigned counter, 14 bits
  assign ix = {origin_x[gab_pkg::DIM_W-1], origin_x} + {6'd0, column_count};
  assign iy = {origin_y[gab_pkg::DIM_W-1], origin_y} + {6'd0, row_count};
  assign visible = !ix[gab_pkg::DIM_W] && !iy[gab_pkg::DIM_W] &&
                   (ix[gab_pkg::DIM_W-1:0] < fb_width) &&
                   (iy[gab_pkg::DIM_W-1:0] < fb_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.capture) begin
      if (end_col) begin
        column_count <= '0;
        row_count    <= end_row ? '0 : row_count + 8'd1;
      end else begin
        column_count <= column_count + 8'd1;
      end
    end
  end

  assign alpha_prod = 16'(blend_color[31:24]) * 16'(cov_q);
  assign row_base   = (2*gab_pkg::DIM_W)'(iy_q) * (2*gab_pkg::DIM_W)'(fb_width);

  assign r_bl = blend_ch(blend_color[23:16], dst_q[23:16], a_q);
  assign g_bl = blend_ch(blend_color[15:8],  dst_q[15:8],  a_q);
  assign b_bl = blend_ch(blend_color[7:0],   dst_q[7:0],   a_q);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cov_q  <= coverage;
      dst_q  <= dst_pixel;
      ix_q   <= ix[gab_pkg::DIM_W-1:0];
      iy_q   <= iy[gab_pkg::DIM_W-1:0];
      vis_q  <= visible;
      last_q <= end_col && end_row;
    end
    if (cmd.calc) begin
      a_q    <= alpha_prod[15:8];
      addr_q <= row_base[gab_pkg::ADDR_W-1:0] +
                {{(gab_pkg::ADDR_W-gab_pkg::DIM_W){1'b0}}, ix_q};
    end
    if (cmd.load_out) begin
      write_enable  <= vis_q;
      pixel_address <= vis_q ? addr_q : '0;
      new_pixel     <= vis_q ? {r_bl, g_bl, b_bl} : '0;
      last          <= last_q;
    end
  end

endmodule

// File: rtl/core/glyph_alpha_blit_top.sv
// ----------------------------------------------------------------------------
// glyph_alpha_blit_top
// Alpha-blended glyph blit onto a 32-bit xRGB framebuffer.
// ----------------------------------------------------------------------------
// One input beat is a coverage byte plus the framebuffer pixel at that spot,
// in glyph row-major order; each produces exactly one output beat with the
// write flag, framebuffer address (row * fb_width + column, low 24 bits) and
// the blended RGB pixel. Clipped positions give write_enable 0 with address
// and pixel zero; last marks the final byte of the glyph. An item passes three
// steps: capture with clip test, the coverage-alpha and row-address
// multiply, then the per-channel blend into the output register. The
// three-step sequencer with its single pair of stage registers takes no
// new beat until the prior one is loaded. The output register lets
// the next beat enter while a finished result is still stalled. The position
// counters persist across config writes; only reset restarts a glyph.
// Write config only while the block is idle.
module glyph_alpha_blit_top (
  input  logic                           clk,
  input  logic                           rst,
  // config write port
  input  logic                           cfg_wr_en,
  input  logic [gab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gab_pkg::CFG_DATA_W-1:0] cfg_data,
  // input beat
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     coverage,
  input  logic [31:0]                    dst_pixel,
  // output beat
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           write_enable,
  output logic [gab_pkg::ADDR_W-1:0]     pixel_address,
  output logic [gab_pkg::PIX_W-1:0]      new_pixel,
  output logic                           last
);

  gab_pkg::gab_cmd_t cmd;

  // sequencer and handshake
  gab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // registers, counters, arithmetic
  gab_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .coverage      (coverage),
    .dst_pixel     (dst_pixel),
    .write_enable  (write_enable),
    .pixel_address (pixel_address),
    .new_pixel     (new_pixel),
    .last          (last)
  );

endmodule
